### hw/rtl/assert_macros.svh
//----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the timer block
//----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define GTAR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GTAR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GTAR_ASSERT(lbl, prop, msg)
`define GTAR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### hw/rtl/gtar_pkg.sv
//----------------------------------------------------------------------------
// gtar_pkg
// types, register offsets and codes of the timer register block
//----------------------------------------------------------------------------
package gtar_pkg;

    // size of the register window in bytes
    localparam int unsigned WINDOW_BYTES = 4096;

    localparam int unsigned OFF_W  = 12;
    localparam int unsigned DATA_W = 32;

    // commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [2:0] ST_UNALIGNED = 3'd3;
    localparam logic [2:0] ST_UNHANDLED = 3'd4;

    // access sizes in bytes
    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    // word offsets of the register map
    localparam logic [OFF_W-1:0] RG_INTR   = 12'h100;
    localparam logic [OFF_W-1:0] RG_INTREN = 12'h140;
    localparam logic [OFF_W-1:0] RG_NUM    = 12'h200;
    localparam logic [OFF_W-1:0] RG_DEN    = 12'h210;
    localparam logic [OFF_W-1:0] RG_TLO    = 12'h400;
    localparam logic [OFF_W-1:0] RG_THI    = 12'h410;
    localparam logic [OFF_W-1:0] RG_ALARM  = 12'h420;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [OFF_W-1:0]  byte_offset;
        logic [2:0]        access_size;
        logic [DATA_W-1:0] write_data;
    } cmd_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [2:0]        status;
        logic              alarm_pending;
    } rsp_word_t;

endpackage

### hw/rtl/gtar_cmd_if.sv
//----------------------------------------------------------------------------
// gtar_cmd_if
// valid/ready channel carrying tick and bus command words
//----------------------------------------------------------------------------
interface gtar_cmd_if;
    logic                valid;
    logic                ready;
    gtar_pkg::cmd_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/gtar_rsp_if.sv
//----------------------------------------------------------------------------
// gtar_rsp_if
// valid/ready channel carrying result words
//----------------------------------------------------------------------------
interface gtar_rsp_if;
    logic                valid;
    logic                ready;
    gtar_pkg::rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/gtar_core.sv
//----------------------------------------------------------------------------
// gpu_timer_alarm_registers_core
// 64-bit timer behind a register window with a signed alarm compare
//----------------------------------------------------------------------------
//
//  channel  | dir | word        | contents
//  ---------+-----+-------------+------------------------------------------
//  cmd_ch   | in  | cmd_word_t  | cmd, byte_offset, access_size, write_data
//  rsp_ch   | out | rsp_word_t  | read_data, status, alarm_pending
//
//  one result word per command word; a word enters the input register,
//  is executed against the register file as it moves into the result
//  register, and one word is taken every cycle while the result side
//  keeps up
//  the tick increment and the alarm subtract sit in the same cycle and set
//  the clock period
//  rsp_ch stalls hold the result register; the input register still fills,
//  then cmd_ch.ready drops until the result is taken
//  reset (rst_n, async, active low) empties both registers and loads the
//  timer registers with their power-on values
//
`include "assert_macros.svh"

module gpu_timer_alarm_registers_core
(
    input  logic       clk,
    input  logic       rst_n,
    gtar_cmd_if.sink   cmd_ch,
    gtar_rsp_if.source rsp_ch
);

    // pipeline control
    logic                s1_valid_reg;
    gtar_pkg::cmd_word_t s1_word_reg;
    logic                out_valid_reg;
    gtar_pkg::rsp_word_t out_word_reg;
    gtar_pkg::rsp_word_t out_word_next;
    logic                advance;
    logic                exec;

    // architectural state
    logic [63:0] time_count_reg,  time_count_next;
    logic        intr_status_reg, intr_status_next;
    logic [31:0] intr_enable_reg, intr_enable_next;
    logic [31:0] rate_num_reg,    rate_num_next;
    logic [31:0] rate_den_reg,    rate_den_next;
    logic [31:0] alarm_reg,       alarm_next;

    // decode of the word held in the input register
    logic [gtar_pkg::OFF_W-1:0] word_addr;
    logic [4:0]                 lane_shift;
    logic                       over_window;
    logic [31:0]                rd_word;
    logic [31:0]                wr_mask;
    logic [31:0]                wr_val;
    logic [2:0]                 wr_status;
    logic [2:0]                 rd_status;
    logic [31:0]                rd_lane;
    logic [31:0]                alarm_diff;

    // result register frees when empty or when its word is taken
    assign advance      = !out_valid_reg || rsp_ch.ready;
    assign exec         = s1_valid_reg && advance;
    assign cmd_ch.ready = !s1_valid_reg || advance;

    assign rsp_ch.valid = out_valid_reg;
    assign rsp_ch.data  = out_word_reg;

    assign word_addr  = {s1_word_reg.byte_offset[gtar_pkg::OFF_W-1:2], 2'b00};
    assign lane_shift = {s1_word_reg.byte_offset[1:0], 3'b000};
    assign over_window = (32'(s1_word_reg.byte_offset) + 32'(s1_word_reg.access_size))
                         > 32'(gtar_pkg::WINDOW_BYTES);

    // register read mux
    always_comb
    begin
        case (word_addr)
            gtar_pkg::RG_INTR:   rd_word = {31'd0, intr_status_reg};
            gtar_pkg::RG_INTREN: rd_word = intr_enable_reg;
            gtar_pkg::RG_NUM:    rd_word = rate_num_reg;
            gtar_pkg::RG_DEN:    rd_word = rate_den_reg;
            gtar_pkg::RG_TLO:    rd_word = time_count_reg[31:0];
            gtar_pkg::RG_THI:    rd_word = time_count_reg[63:32];
            gtar_pkg::RG_ALARM:  rd_word = alarm_reg;
            default:             rd_word = 32'd0;
        endcase
    end

    // read lane select; unaligned reads are allowed
    always_comb
    begin
        rd_lane   = 32'd0;
        rd_status = gtar_pkg::ST_OK;
        if (over_window)
        begin
            rd_status = gtar_pkg::ST_RANGE;
        end
        else
        begin
            case (s1_word_reg.access_size)
                gtar_pkg::SIZE_BYTE: rd_lane = (rd_word >> lane_shift) & 32'h0000_00ff;
                gtar_pkg::SIZE_HALF: rd_lane = (rd_word >> lane_shift) & 32'h0000_ffff;
                gtar_pkg::SIZE_WORD: rd_lane = rd_word;
                default:             rd_status = gtar_pkg::ST_BAD_SIZE;
            endcase
        end
    end

    // write byte mask and lane-aligned value
    always_comb
    begin
        wr_mask   = 32'd0;
        wr_val    = 32'd0;
        wr_status = gtar_pkg::ST_OK;
        if (over_window)
        begin
            wr_status = gtar_pkg::ST_RANGE;
        end
        else
        begin
            case (s1_word_reg.access_size)
                gtar_pkg::SIZE_BYTE:
                begin
                    wr_mask = 32'h0000_00ff << lane_shift;
                    wr_val  = (s1_word_reg.write_data & 32'h0000_00ff) << lane_shift;
                end
                gtar_pkg::SIZE_HALF:
                begin
                    if (s1_word_reg.byte_offset[0])
                    begin
                        wr_status = gtar_pkg::ST_UNALIGNED;
                    end
                    wr_mask = 32'h0000_ffff << lane_shift;
                    wr_val  = (s1_word_reg.write_data & 32'h0000_ffff) << lane_shift;
                end
                gtar_pkg::SIZE_WORD:
                begin
                    if (s1_word_reg.byte_offset[1:0] != 2'b00)
                    begin
                        wr_status = gtar_pkg::ST_UNALIGNED;
                    end
                    wr_mask = 32'hffff_ffff;
                    wr_val  = s1_word_reg.write_data;
                end
                default:
                begin
                    wr_status = gtar_pkg::ST_BAD_SIZE;
                end
            endcase
        end
    end

    // execute one word against the register file
    always_comb
    begin
        time_count_next  = time_count_reg;
        intr_status_next = intr_status_reg;
        intr_enable_next = intr_enable_reg;
        rate_num_next    = rate_num_reg;
        rate_den_next    = rate_den_reg;
        alarm_next       = alarm_reg;
        out_word_next    = '0;

        case (s1_word_reg.cmd)
            gtar_pkg::CMD_TICK:
            begin
                time_count_next = time_count_reg + 64'd1;
            end
            gtar_pkg::CMD_READ:
            begin
                out_word_next.read_data = rd_lane;
                out_word_next.status    = rd_status;
            end
            gtar_pkg::CMD_WRITE:
            begin
                out_word_next.status = wr_status;
                if (wr_status == gtar_pkg::ST_OK)
                begin
                    case (word_addr)
                        gtar_pkg::RG_INTR:
                            // write one to clear
                            intr_status_next = intr_status_reg & !wr_val[0];
                        gtar_pkg::RG_INTREN:
                            intr_enable_next = (intr_enable_reg & ~wr_mask) | (wr_val & wr_mask);
                        gtar_pkg::RG_NUM:
                            rate_num_next = (rate_num_reg & ~wr_mask) | (wr_val & wr_mask);
                        gtar_pkg::RG_DEN:
                            rate_den_next = (rate_den_reg & ~wr_mask) | (wr_val & wr_mask);
                        gtar_pkg::RG_TLO:
                            time_count_next[31:0] =
                                (time_count_reg[31:0] & ~wr_mask) | (wr_val & wr_mask);
                        gtar_pkg::RG_THI:
                            time_count_next[63:32] =
                                (time_count_reg[63:32] & ~wr_mask) | (wr_val & wr_mask);
                        gtar_pkg::RG_ALARM:
                            alarm_next = (alarm_reg & ~wr_mask) | (wr_val & wr_mask);
                        default:
                            out_word_next.status = gtar_pkg::ST_UNHANDLED;
                    endcase
                end
            end
            default:
            begin
                // unused command: only the alarm check below
            end
        endcase

        // alarm fires, when enabled, once time low has reached the alarm, wrap-safe compare
        alarm_diff = time_count_next[31:0] - alarm_next;
        if (intr_enable_next[0] && !alarm_diff[31])
        begin
            intr_status_next = 1'b1;
        end

        out_word_next.alarm_pending = intr_status_next;
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            time_count_reg  <= 64'd0;
            intr_status_reg <= 1'b0;
            intr_enable_reg <= 32'd0;
            rate_num_reg    <= 32'd1;
            rate_den_reg    <= 32'd1;
            alarm_reg       <= 32'hffff_ffff;
        end
        else
        begin
            if (cmd_ch.ready)
            begin
                s1_valid_reg <= cmd_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (exec)
            begin
                time_count_reg  <= time_count_next;
                intr_status_reg <= intr_status_next;
                intr_enable_reg <= intr_enable_next;
                rate_num_reg    <= rate_num_next;
                rate_den_reg    <= rate_den_next;
                alarm_reg       <= alarm_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_ch.valid && cmd_ch.ready)
        begin
            s1_word_reg <= cmd_ch.data;
        end
        if (exec)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // pending bit shown with a result matches the live interrupt status
    `GTAR_ASSERT(a_pending_matches, out_valid_reg |-> (out_word_reg.alarm_pending == intr_status_reg), "alarm_pending out of step with interrupt status")

    // an executed tick advances the counter by exactly one
    `GTAR_ASSERT(a_tick_step, (exec && s1_word_reg.cmd == gtar_pkg::CMD_TICK) |=> (time_count_reg == $past(time_count_reg) + 64'd1), "tick did not advance the counter by one")

    // nonzero read data only comes with a successful access
    `GTAR_ASSERT(a_data_ok, (out_valid_reg && out_word_reg.read_data != 32'd0) |-> (out_word_reg.status == gtar_pkg::ST_OK), "read data returned with an error status")

    // state holds while no word executes
    `GTAR_ASSERT(a_state_hold, !exec |=> ($stable(time_count_reg) && $stable(alarm_reg) && $stable(intr_status_reg)), "timer state changed without an executed word")

    // full input register behind a stalled result must back-pressure
    `GTAR_ASSERT_ALWAYS(a_backpressure, (s1_valid_reg && out_valid_reg && !rsp_ch.ready) |-> !cmd_ch.ready, "command accepted while both stages are full")

endmodule

### verif/gtar_checker.sv
`timescale 1ns / 1ps
//----------------------------------------------------------------------------
// gtar_checker
// watches both channels of the timer block, keeps its own copy of the timer
// registers, works out the result of every accepted command word and
// compares it field by field with the result words that come back
//----------------------------------------------------------------------------
module gtar_checker
    import gtar_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    gtar_cmd_if  cmd_mon,
    gtar_rsp_if  rsp_mon,
    output int   mismatches,
    output int   owed_count,
    output int   checked_count,
    output int   alarm_count
);

    // shadow copy of the timer registers
    logic [63:0] count_q;
    logic        irq_flag;
    logic [31:0] irq_en;
    logic [31:0] rate_num;
    logic [31:0] rate_den;
    logic [31:0] alarm_reg;

    // results owed by the block, oldest first
    rsp_word_t owed_results[$];

    function automatic logic [31:0] blend(logic [31:0] old_v, logic [31:0] new_v,
                                          logic [31:0] m);
        return (old_v & ~m) | (new_v & m);
    endfunction

    function automatic logic [31:0] fetch_reg(logic [OFF_W-1:0] word_off);
        case (word_off)
            RG_INTR:   return {31'd0, irq_flag};
            RG_INTREN: return irq_en;
            RG_NUM:    return rate_num;
            RG_DEN:    return rate_den;
            RG_TLO:    return count_q[31:0];
            RG_THI:    return count_q[63:32];
            RG_ALARM:  return alarm_reg;
            default:   return 32'd0;
        endcase
    endfunction

    // applies one command word to the shadow registers and forms its result
    task automatic timer_step(input cmd_word_t w, output rsp_word_t r);
        logic [12:0]      span;
        logic [4:0]       shift;
        logic [OFF_W-1:0] word_off;
        logic [31:0]      mask;
        logic [31:0]      val;
        logic [31:0]      rd;
        logic [31:0]      diff;
        logic [2:0]       st;
        span     = {1'b0, w.byte_offset} + {10'd0, w.access_size};
        shift    = {w.byte_offset[1:0], 3'b000};
        word_off = {w.byte_offset[OFF_W-1:2], 2'b00};
        mask     = 32'd0;
        val      = 32'd0;
        rd       = 32'd0;
        st       = ST_OK;
        case (w.cmd)
            CMD_TICK: count_q = count_q + 64'd1;
            CMD_READ:
            begin
                if (span > 13'(WINDOW_BYTES))
                    st = ST_RANGE;
                else if (w.access_size != SIZE_BYTE && w.access_size != SIZE_HALF &&
                         w.access_size != SIZE_WORD)
                    st = ST_BAD_SIZE;
                else
                begin
                    val = fetch_reg(word_off);
                    if (w.access_size == SIZE_BYTE)
                        rd = (val >> shift) & 32'hFF;
                    else if (w.access_size == SIZE_HALF)
                        rd = (val >> shift) & 32'hFFFF;
                    else
                        rd = val;
                end
            end
            CMD_WRITE:
            begin
                if (span > 13'(WINDOW_BYTES))
                    st = ST_RANGE;
                else if (w.access_size == SIZE_BYTE)
                begin
                    mask = 32'hFF << shift;
                    val  = {24'd0, w.write_data[7:0]} << shift;
                end
                else if (w.access_size == SIZE_HALF)
                begin
                    if (w.byte_offset[0])
                        st = ST_UNALIGNED;
                    mask = 32'hFFFF << shift;
                    val  = {16'd0, w.write_data[15:0]} << shift;
                end
                else if (w.access_size == SIZE_WORD)
                begin
                    if (w.byte_offset[1:0] != 2'd0)
                        st = ST_UNALIGNED;
                    mask = 32'hFFFF_FFFF;
                    val  = w.write_data;
                end
                else
                    st = ST_BAD_SIZE;
                if (st == ST_OK)
                begin
                    case (word_off)
                        RG_INTR:   if (val[0]) irq_flag = 1'b0;
                        RG_INTREN: irq_en = blend(irq_en, val, mask);
                        RG_NUM:    rate_num = blend(rate_num, val, mask);
                        RG_DEN:    rate_den = blend(rate_den, val, mask);
                        RG_TLO:    count_q[31:0] = blend(count_q[31:0], val, mask);
                        RG_THI:    count_q[63:32] = blend(count_q[63:32], val, mask);
                        RG_ALARM:  alarm_reg = blend(alarm_reg, val, mask);
                        default:   st = ST_UNHANDLED;
                    endcase
                end
            end
            default: ;
        endcase
        // alarm compare after every word, signed distance of time low to alarm
        diff = count_q[31:0] - alarm_reg;
        if (irq_en[0] && !diff[31])
            irq_flag = 1'b1;
        r.read_data     = rd;
        r.status        = st;
        r.alarm_pending = irq_flag;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t got;
        rsp_word_t want;
        rsp_word_t nxt;
        if (!rst_n)
        begin
            count_q   = 64'd0;
            irq_flag  = 1'b0;
            irq_en    = 32'd0;
            rate_num  = 32'd1;
            rate_den  = 32'd1;
            alarm_reg = 32'hFFFF_FFFF;
            owed_results.delete();
            mismatches    = 0;
            owed_count    = 0;
            checked_count = 0;
            alarm_count   = 0;
        end
        else
        begin
            // the result side first: a word taken at this edge is never
            // answered at the same edge
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                got = rsp_mon.data;
                checked_count++;
                if (got.alarm_pending)
                    alarm_count++;
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result word, expected none, actual %h/%0d/%0b",
                             $time, got.read_data, got.status, got.alarm_pending);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.read_data !== want.read_data)
                    begin
                        mismatches++;
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, got.read_data);
                    end
                    if (got.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.alarm_pending !== want.alarm_pending)
                    begin
                        mismatches++;
                        $display("%0t: alarm_pending expected %0b actual %0b",
                                 $time, want.alarm_pending, got.alarm_pending);
                    end
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                timer_step(cmd_mon.data, nxt);
                owed_results.push_back(nxt);
            end
            owed_count = owed_results.size();
        end
    end

endmodule

### verif/gpu_timer_alarm_registers_core_tb.sv
`timescale 1ns / 1ps
//----------------------------------------------------------------------------
// gpu_timer_alarm_registers_core_tb
// drives ticks, register reads and register writes into the timer block
// under changing idle and stall patterns; the checker beside the block
// predicts every result word and the verdict comes from its failure count
//----------------------------------------------------------------------------
module gpu_timer_alarm_registers_core_tb;
    import gtar_pkg::*;

    // the fourth command code, which the block must treat as a no-op
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int RANDOM_WORDS = 1100;
    localparam int CYCLE_LIMIT  = 200000;
    // drain time once nothing is owed, to catch stray result words
    localparam int DRAIN_CYCLES = 8;
    // long enough to fill both internal registers and stall the command side
    localparam int LONG_HOLD    = 48;

    logic clk = 1'b0;
    logic rst_n;

    gtar_cmd_if cmd_ch ();
    gtar_rsp_if rsp_ch ();

    // percent chance per cycle that the sender idles or the receiver stalls
    int send_idle_pct = 0;
    int stall_pct     = 0;
    // cycles left in a forced receiver hold-off
    int hold_left     = 0;
    int cycle_count   = 0;

    // words accepted per command kind, for the summary
    int n_tick  = 0;
    int n_read  = 0;
    int n_write = 0;
    int n_spare = 0;

    int mismatches;
    int owed_count;
    int checked_count;
    int alarm_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gpu_timer_alarm_registers_core u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .rsp_ch (rsp_ch)
    );

    gtar_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_mon       (cmd_ch),
        .rsp_mon       (rsp_ch),
        .mismatches    (mismatches),
        .owed_count    (owed_count),
        .checked_count (checked_count),
        .alarm_count   (alarm_count)
    );

    // result side ready: random stalls, or a forced hold-off counted here
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on the whole run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: cycle limit of %0d reached", $time, CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    function automatic cmd_word_t bus_word(logic [1:0] cmd, logic [OFF_W-1:0] off,
                                           logic [2:0] size, logic [31:0] wdata);
        cmd_word_t w;
        w.cmd         = cmd;
        w.byte_offset = off;
        w.access_size = size;
        w.write_data  = wdata;
        return w;
    endfunction

    function automatic logic [OFF_W-1:0] pick_reg();
        case ($urandom_range(6))
            0:       return RG_INTR;
            1:       return RG_INTREN;
            2:       return RG_NUM;
            3:       return RG_DEN;
            4:       return RG_TLO;
            5:       return RG_THI;
            default: return RG_ALARM;
        endcase
    endfunction

    // mostly well-formed register traffic and ticks, with some junk mixed in
    function automatic cmd_word_t pick_word();
        cmd_word_t   w;
        int          r;
        logic [1:0]  lane;
        r = $urandom_range(99);
        // write data: fully random, small (to land the alarm near time low),
        // or just below a wrap (to make time low carry into time high)
        case ($urandom_range(3))
            0, 1:    w.write_data = $urandom;
            2:       w.write_data = 32'($urandom_range(48));
            default: w.write_data = 32'hFFFF_FFF0 | 32'($urandom_range(15));
        endcase
        if (r < 35)
        begin
            // a tick carries junk in the other fields
            w.cmd         = CMD_TICK;
            w.byte_offset = OFF_W'($urandom);
            w.access_size = 3'($urandom);
        end
        else if (r < 88)
        begin
            w.cmd = ($urandom_range(1) == 0) ? CMD_READ : CMD_WRITE;
            lane  = 2'($urandom);
            case ($urandom_range(2))
                0:
                begin
                    w.access_size = SIZE_BYTE;
                end
                1:
                begin
                    w.access_size = SIZE_HALF;
                    lane[0] = 1'b0;
                end
                default:
                begin
                    w.access_size = SIZE_WORD;
                    lane = 2'd0;
                end
            endcase
            // now and then a read off its natural lane, which is legal
            if (w.cmd == CMD_READ && $urandom_range(9) == 0)
                lane = 2'($urandom);
            w.byte_offset = pick_reg() | {10'd0, lane};
        end
        else if (r < 92)
        begin
            w.cmd         = CMD_SPARE;
            w.byte_offset = OFF_W'($urandom);
            w.access_size = 3'($urandom);
        end
        else
        begin
            // junk access: any offset, often at the top of the window, any size
            w.cmd         = ($urandom_range(1) == 0) ? CMD_READ : CMD_WRITE;
            w.byte_offset = ($urandom_range(3) == 0) ? OFF_W'(4088 + $urandom_range(7))
                                                     : OFF_W'($urandom);
            w.access_size = 3'($urandom);
        end
        return w;
    endfunction

    // offers one word at a falling edge and returns at the falling edge
    // after it was taken; idle cycles go in front of it
    task automatic send_word(input cmd_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= w;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        case (w.cmd)
            CMD_TICK:  n_tick++;
            CMD_READ:  n_read++;
            CMD_WRITE: n_write++;
            default:   n_spare++;
        endcase
        @(negedge clk);
    endtask

    initial
    begin
        int ph;
        int i;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words, no idling
        // alarm reads back its power-on all-ones value
        send_word(bus_word(CMD_READ, RG_ALARM, SIZE_WORD, 32'd0));
        // a tick ignores whatever sits in the other fields
        send_word(bus_word(CMD_TICK, 12'hFFF, 3'd7, 32'hDEAD_BEEF));
        // load the counter two below a 64-bit wrap, then wrap it
        send_word(bus_word(CMD_WRITE, RG_THI, SIZE_WORD, 32'hFFFF_FFFF));
        send_word(bus_word(CMD_WRITE, RG_TLO, SIZE_WORD, 32'hFFFF_FFFE));
        send_word(bus_word(CMD_TICK, 12'h000, 3'd0, 32'd0));
        send_word(bus_word(CMD_TICK, 12'h000, 3'd0, 32'd0));
        send_word(bus_word(CMD_READ, RG_THI, SIZE_WORD, 32'd0));
        // enable with a byte write, upper data bits must be dropped
        send_word(bus_word(CMD_WRITE, RG_INTREN, SIZE_BYTE, 32'hFFFF_FF01));
        // arm the alarm at 5, then move time low onto it with a half write
        send_word(bus_word(CMD_WRITE, RG_ALARM, SIZE_WORD, 32'd5));
        send_word(bus_word(CMD_WRITE, RG_TLO, SIZE_HALF, 32'hAAAA_0005));
        // clear while the condition still holds: the bit comes straight back
        send_word(bus_word(CMD_WRITE, RG_INTR, SIZE_WORD, 32'd1));
        // push the alarm half a range away so the distance turns negative
        send_word(bus_word(CMD_WRITE, RG_ALARM | 12'd3, SIZE_BYTE, 32'h0000_0080));
        // this clear now sticks
        send_word(bus_word(CMD_WRITE, RG_INTR, SIZE_BYTE, 32'h0000_00FF));
        send_word(bus_word(CMD_READ, RG_INTR, SIZE_BYTE, 32'd0));
        // past the end of the window, range wins over alignment
        send_word(bus_word(CMD_READ, 12'hFFF, SIZE_WORD, 32'd0));
        send_word(bus_word(CMD_WRITE, 12'hFFF, SIZE_HALF, 32'hFFFF_FFFF));
        // sizes that are not 1, 2 or 4
        send_word(bus_word(CMD_READ, RG_INTREN, 3'd3, 32'd0));
        send_word(bus_word(CMD_WRITE, RG_NUM, 3'd0, 32'hFFFF_FFFF));
        // misaligned writes
        send_word(bus_word(CMD_WRITE, RG_NUM | 12'd1, SIZE_HALF, 32'h1234_5678));
        send_word(bus_word(CMD_WRITE, RG_DEN | 12'd2, SIZE_WORD, 32'h1234_5678));
        // upper half of the denominator, then one byte of it read back
        send_word(bus_word(CMD_WRITE, RG_DEN | 12'd2, SIZE_HALF, 32'hABCD_1234));
        send_word(bus_word(CMD_READ, RG_DEN | 12'd3, SIZE_BYTE, 32'd0));
        // holes in the map: reads give zero, writes are refused
        send_word(bus_word(CMD_READ, RG_INTR | 12'd4, SIZE_WORD, 32'd0));
        send_word(bus_word(CMD_WRITE, 12'h300, SIZE_WORD, 32'hFFFF_FFFF));
        send_word(bus_word(CMD_SPARE, RG_TLO, SIZE_WORD, 32'hFFFF_FFFF));

        // random traffic in four idling phases
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    // receiver holds off while words keep coming
                    hold_left     = LONG_HOLD;
                end
                1:
                begin
                    send_idle_pct = 76;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 76;
                end
                default:
                begin
                    send_idle_pct = 19;
                    stall_pct     = 19;
                end
            endcase
            for (i = 0; i < RANDOM_WORDS / 4; i++)
                send_word(pick_word());
        end
        cmd_ch.valid <= 1'b0;
        stall_pct = 0;

        // wait for every owed result, then a little longer for strays
        while (owed_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d words: %0d ticks, %0d reads, %0d writes, %0d unused commands",
                 n_tick + n_read + n_write + n_spare, n_tick, n_read, n_write, n_spare);
        $display("checked %0d results, %0d with the alarm pending, %0d left owed",
                 checked_count, alarm_count, owed_count);
        if (mismatches == 0 && owed_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
